>>> rtl/small_set_store_defines.svh
// Assertion macros used by the set store RTL.
`ifndef SMALL_SET_STORE_DEFINES_SVH
`define SMALL_SET_STORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("small_set_store: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("small_set_store: next-cycle check failed");

`endif

>>> rtl/sss_pkg.sv
`default_nettype none

package sss_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int COUNT_W      = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic               ins;
    logic               del;
    logic               clr;
    logic [VALUE_W-1:0] key;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sss_cell.sv
`default_nettype none

module sss_cell import sss_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_cmd_t          cmd,
  input  wire logic               prev_occ,
  input  wire logic               next_occ,
  input  wire logic [VALUE_W-1:0] next_val,
  input  wire logic               kill_in,
  output      logic               kill_out,
  output      logic               match,
  output      logic               occ,
  output      logic [VALUE_W-1:0] val
);

  logic               occ_r, occ_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               shift;

  assign match    = occ_r && (val_r == cmd.key);
  assign kill_out = kill_in | match;
  // take the right neighbor's word once the removed entry is at or left of us
  assign shift    = cmd.del && kill_out;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (cmd.clr) begin
      occ_nxt = 1'b0;
    end else if (shift) begin
      occ_nxt = next_occ;
      val_nxt = next_val;
    end else if (cmd.ins && prev_occ && !occ_r) begin
      occ_nxt = 1'b1;
      val_nxt = cmd.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign occ = occ_r;
  assign val = val_r;

endmodule

`default_nettype wire

>>> rtl/small_set_store.sv
// Set store with room for CAPACITY distinct signed 32-bit words, held in
// insertion order in a row of cells. A command is taken on any rising edge
// with start high; busy is always low, so one command is taken every cycle.
// Its result (hit, count, status) is shown on the out_ ports for exactly one
// cycle, marked by out_valid, in the cycle after the command was taken; the
// receiver cannot stall and must sample it then. Every cell compares its word
// against the key at once, and a remove closes the gap by having each cell
// at or right of the match (found by the match chain that runs along the row)
// take its right neighbor's word in the same cycle. Insert of a word already
// held reports hit; insert into a full store is dropped with status set.
// Clear empties the store and reports count zero. Reset empties it too.
`default_nettype none

`include "small_set_store_defines.svh"

module small_set_store import sss_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic        [KIND_W-1:0]  in_kind,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output      logic                      out_valid,
  output      logic                      out_hit,
  output      logic        [COUNT_W-1:0] out_count,
  output      logic                      out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                accept;
  cell_cmd_t           cmd;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY:0]   kill;
  logic [VALUE_W-1:0]  val [CAPACITY];

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             hit, full;
  logic             is_ins, is_del, is_clr;

  logic               out_valid_r, out_hit_r, out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [CNT_W+COUNT_W-1:0] fill_ext;

  // one command per cycle: never hold off the requester
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_ins = accept && (in_kind == KIND_INSERT);
  assign is_del = accept && (in_kind == KIND_REMOVE);
  assign is_clr = accept && (in_kind == KIND_CLEAR);

  // the match chain leaves the last cell high when any cell holds the key
  assign hit  = kill[CAPACITY];
  assign full = (fill_r == CNT_W'(CAPACITY));

  // drop an insert that is a duplicate or that finds no free cell
  assign cmd.ins = is_ins && !hit && !full;
  assign cmd.del = is_del;
  assign cmd.clr = is_clr;
  assign cmd.key = in_value;

  assign kill[0] = 1'b0;

  // row of cells: cell 0 is the oldest entry, free cells sit on the right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_occ_w, next_occ_w;
    logic [VALUE_W-1:0] next_val_w;

    if (i == 0) begin : g_first
      assign prev_occ_w = 1'b1;
    end else begin : g_inner
      assign prev_occ_w = occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_occ_w = 1'b0;
      assign next_val_w = val[i];
    end else begin : g_body
      assign next_occ_w = occ[i+1];
      assign next_val_w = val[i+1];
    end

    sss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_occ (prev_occ_w),
      .next_occ (next_occ_w),
      .next_val (next_val_w),
      .kill_in  (kill[i]),
      .kill_out (kill[i+1]),
      .match    (match[i]),
      .occ      (occ[i]),
      .val      (val[i])
    );
  end

  // advance the fill count alongside the cells
  always_comb begin
    fill_nxt = fill_r;
    if (is_clr) begin
      fill_nxt = '0;
    end else if (cmd.ins) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (is_del && hit) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  // count port keeps the low bits of the fill count
  assign fill_ext = {{COUNT_W{1'b0}}, fill_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= accept;
    end
  end

  // result word: hold for the one cycle that out_valid marks
  always_ff @(posedge clk) begin
    out_hit_r    <= hit && !is_clr;
    out_count_r  <= fill_ext[COUNT_W-1:0];
    out_status_r <= is_ins && !hit && full;
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  // fill count tracks the occupied cells
  `SSS_ASSERT_NOW(a_fill_matches_row, 1'b1, $countones(occ) == int'(fill_r))
  // occupied cells form an unbroken run from cell 0
  `SSS_ASSERT_NOW(a_row_packed, 1'b1, ((occ + CAPACITY'(1)) & occ) == '0)
  // a held word never appears in two cells
  `SSS_ASSERT_NOW(a_match_unique, 1'b1, $onehot0(match))
  // every taken command yields one result the next cycle
  `SSS_ASSERT_NEXT(a_result_follows, accept, out_valid)

endmodule

`default_nettype wire

>>> dv/tb_small_set_store.sv
`timescale 1ns / 1ps

module tb_small_set_store;
  import sss_pkg::*;

  // Stop the run if this many cycles pass with no word taken on either side.
  localparam int STALL_LIMIT = 400;
  // Size of the value pool that the random part draws from. It is larger than
  // the store, so inserts hit the full case while removes and lookups still hit.
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 650;

  // One result word as the block should report it.
  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic               status;
  } set_result_t;

  // Mirror of the store contents; predicts the result word of each command
  // and checks the words that come back.
  class set_store_mirror;
    logic [VALUE_W-1:0] slots [DEF_CAPACITY];
    int unsigned        fill;
    set_result_t        expected_words [$];
    int                 errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Return the slot holding v, or fill when it is not held.
    function int unsigned slot_of(logic [VALUE_W-1:0] v);
      int unsigned i;
      for (i = 0; i < fill; i++) begin
        if (slots[i] === v) return i;
      end
      return fill;
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] v);
      set_result_t r;
      int unsigned pos;
      int unsigned i;
      r = '0;
      case (kind)
        KIND_INSERT: begin
          pos = slot_of(v);
          if (pos < fill) begin
            r.hit = 1'b1;
          end else if (fill >= DEF_CAPACITY) begin
            r.status = 1'b1;
          end else begin
            slots[fill] = v;
            fill++;
          end
        end
        KIND_REMOVE: begin
          pos = slot_of(v);
          if (pos < fill) begin
            r.hit = 1'b1;
            for (i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
          end
        end
        KIND_LOOKUP: begin
          r.hit = (slot_of(v) < fill);
        end
        default: begin
          fill = 0;
        end
      endcase
      r.count = COUNT_W'(fill);
      expected_words = {expected_words, r};
    endfunction

    function void check_result(logic hit, logic [COUNT_W-1:0] count, logic status);
      set_result_t exp_word;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: hit=%0b count=%0d status=%0b",
               hit, count, status);
        errors++;
        return;
      end
      exp_word = expected_words.pop_front();
      if (hit !== exp_word.hit) begin
        $error("hit: expected %0b, got %0b", exp_word.hit, hit);
        errors++;
      end
      if (count !== exp_word.count) begin
        $error("count: expected %0d, got %0d", exp_word.count, count);
        errors++;
      end
      if (status !== exp_word.status) begin
        $error("status: expected %0b, got %0b", exp_word.status, status);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic        [KIND_W-1:0]  in_kind;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_hit;
  logic        [COUNT_W-1:0] out_count;
  logic                      out_status;

  set_store_mirror    mirror;
  logic [VALUE_W-1:0] pool [POOL_SIZE];
  int                 quiet_cycles;

  small_set_store uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_hit    (out_hit),
    .out_count  (out_count),
    .out_status (out_status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sample both channels at the rising edge. A result word seen here belongs
  // to a command taken on an earlier edge, so check it before noting the
  // command that is taken on this same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) mirror.check_result(out_hit, out_count, out_status);
      if (start && !busy) mirror.note_command(in_kind, in_value);
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      // Give up when the block has gone silent for too long.
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_small_set_store: FAIL");
        $finish;
      end
    end
  end

  // Present one command word at the falling edge and hold it until it is
  // taken. Start stays high for the next word unless a hold-off lowers it.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] v);
    @(negedge clk);
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Idle the sender, pct times in a hundred. Drive junk on
  // the payload while start is low; the block must ignore it.
  task automatic hold_off(input int pct);
    int n;
    if (int'($urandom_range(99)) < pct) begin
      n = $urandom_range(4, 1);
      @(negedge clk);
      start    <= 1'b0;
      in_kind  <= KIND_W'($urandom);
      in_value <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Refill the pool: the four corner values plus random words.
  task automatic refresh_pool();
    int i;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (i = 4; i < POOL_SIZE; i++) pool[i] = $urandom;
  endtask

  // Mostly pool values so that hits, removes of held words and full inserts
  // are common; some single-bit neighbors of pool values to catch loose
  // compares; a few fully random words.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 75) return pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 90) return pool[$urandom_range(POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(31));
    return $urandom;
  endfunction

  // Random commands, weighted toward inserts so the store often runs full;
  // clears are rare so it has time to fill between them.
  task automatic run_random(input int items, input int pct);
    int n;
    int r;
    logic [KIND_W-1:0] kind;
    refresh_pool();
    for (n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 45)      kind = KIND_INSERT;
      else if (r < 70) kind = KIND_REMOVE;
      else if (r < 96) kind = KIND_LOOKUP;
      else             kind = KIND_CLEAR;
      send_word(kind, pick_value());
      hold_off(pct);
    end
  endtask

  initial begin
    int i;
    mirror       = new();
    quiet_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_kind      = KIND_INSERT;
    in_value     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: clear on an empty store, the corner values, a duplicate
    // insert, lookups that hit and miss, a remove of an absent value and a
    // remove from the middle so the later entry has to slide down.
    send_word(KIND_CLEAR,  32'h0000_0000);
    send_word(KIND_INSERT, 32'h8000_0000);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'h7FFF_FFFF);
    send_word(KIND_LOOKUP, 32'h8000_0000);
    send_word(KIND_LOOKUP, 32'h0000_0001);
    send_word(KIND_REMOVE, 32'h1234_5678);
    send_word(KIND_REMOVE, 32'h0000_0000);
    send_word(KIND_LOOKUP, 32'hFFFF_FFFF);
    // Fill the store to the brim, push one more in, then drop the head.
    for (i = 0; i < DEF_CAPACITY - 3; i++) send_word(KIND_INSERT, 32'h0001_0000 + i);
    send_word(KIND_INSERT, 32'h5555_5555);
    send_word(KIND_REMOVE, 32'h8000_0000);

    // Random part: light sender idling, then heavy, then back to back.
    run_random(PHASE_ITEMS, 14);
    run_random(PHASE_ITEMS, 63);
    run_random(PHASE_ITEMS, 0);

    // Drain: drop start, wait for the last result word, then keep watching
    // so a stray word would still be caught.
    @(negedge clk);
    start <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("tb_small_set_store: PASS");
    end else begin
      $display("tb_small_set_store: FAIL");
    end
    $finish;
  end

endmodule
